FILE: sv/efc_pkg.sv
package efc_pkg;

	// reported state codes
	typedef enum logic [2:0] {
		ST_IDLE        = 3'd0,
		ST_OPEN        = 3'd1,
		ST_UP          = 3'd2,
		ST_DOWN        = 3'd3,
		ST_FAULT       = 3'd4,
		ST_EMERG_START = 3'd5,
		ST_EMERGENCY   = 3'd6,
		ST_EMERG_STOP  = 3'd7
	} state_t;

	typedef enum logic [1:0] {
		FLT_NONE     = 2'd0,
		FLT_EMPTY    = 2'd1,
		FLT_TOO_MANY = 2'd2,
		FLT_ON_FLOOR = 2'd3
	} fault_t;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_KEY   = 2'd1,
		CMD_EMERG = 2'd2
	} cmd_t;

	localparam logic [7:0]  KEY_CONFIRM = 8'h41;
	localparam logic [7:0]  KEY_ZERO    = 8'h30;
	localparam logic [7:0]  DIGIT_LIMIT = 8'd11;
	localparam logic [3:0]  DIGIT_WIDE  = 4'd10;
	localparam logic [13:0] SCALE_TEN   = 14'd10;
	localparam logic [13:0] SCALE_HUND  = 14'd100;
	localparam logic [13:0] FLOOR_MAX   = 14'd99;
	localparam logic [6:0]  FLOOR_RESET = 7'd1;

	localparam int Q_DEPTH = 4;

	typedef struct packed {
		state_t     reported_state;
		logic       announce;
		logic [6:0] floor_now;
		logic [6:0] floor_target;
		logic       door_is_open;
		fault_t     fault_code;
		logic       last;
	} result_t;

	// results produced by one accepted event
	typedef struct packed {
		logic    push;
		logic    two;
		result_t r0;
		result_t r1;
	} push_t;

endpackage

FILE: sv/efc_evt_if.sv
interface efc_evt_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] key_code;

	modport source (output valid, command, key_code, input ready);
	modport sink   (input valid, command, key_code, output ready);
	modport mon    (input valid, ready, command, key_code);
endinterface

FILE: sv/efc_res_if.sv
interface efc_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] reported_state;
	logic       announce;
	logic [6:0] floor_now;
	logic [6:0] floor_target;
	logic       door_is_open;
	logic [1:0] fault_code;
	logic       last;

	modport source (output valid, reported_state, announce, floor_now, floor_target,
		door_is_open, fault_code, last, input ready);
	modport sink   (input valid, reported_state, announce, floor_now, floor_target,
		door_is_open, fault_code, last, output ready);
	modport mon    (input valid, ready, reported_state, announce, floor_now, floor_target,
		door_is_open, fault_code, last);
endinterface

FILE: sv/efc_ctrl.sv
module efc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [1:0]       command,
	input  logic [7:0]       key_code,
	output efc_pkg::push_t   push
);
	import efc_pkg::*;

	typedef enum logic [2:0] {
		M_IDLE  = 3'd0,
		M_OPEN  = 3'd1,
		M_UP    = 3'd2,
		M_DOWN  = 3'd3,
		M_EWAIT = 3'd5
	} mode_t;

	mode_t      mode_q, mode_d;
	logic [6:0] floor_q, floor_d;
	logic [6:0] target_q, target_d;
	logic [1:0] dcnt_q, dcnt_d;
	logic [6:0] entry_q, entry_d;
	logic       door_q, door_d;

	state_t     st0, st1;
	logic       ann0, two;
	fault_t     flt0;
	logic [7:0] dig;
	logic [3:0] dig4;
	logic [13:0] combined;

	function automatic state_t mode_code(mode_t m);
		state_t s;
		case (m)
			M_OPEN:  s = ST_OPEN;
			M_UP:    s = ST_UP;
			M_DOWN:  s = ST_DOWN;
			M_EWAIT: s = ST_EMERG_START;
			default: s = ST_IDLE;
		endcase
		return s;
	endfunction

	assign dig      = key_code - KEY_ZERO;
	assign dig4     = dig[3:0];
	assign combined = {7'd0, entry_q} * ((dig4 >= DIGIT_WIDE) ? SCALE_HUND : SCALE_TEN)
		+ {10'd0, dig4};

	always_comb begin
		mode_d   = mode_q;
		floor_d  = floor_q;
		target_d = target_q;
		dcnt_d   = dcnt_q;
		entry_d  = entry_q;
		door_d   = door_q;
		st0      = mode_code(mode_q);
		st1      = ST_IDLE;
		ann0     = 1'b0;
		two      = 1'b0;
		flt0     = FLT_NONE;

		case (command)
			CMD_TICK: begin
				case (mode_q)
					M_OPEN: begin
						ann0 = 1'b1;
						if (!door_q) begin
							door_d = 1'b1;
							st0    = ST_OPEN;
						end else begin
							door_d = 1'b0;
							mode_d = M_IDLE;
							st0    = ST_IDLE;
						end
					end
					M_UP: begin
						if (target_q > floor_q) begin
							floor_d = floor_q + 7'd1;
						end else if (target_q == floor_q) begin
							mode_d = M_OPEN;
							st0    = ST_OPEN;
						end
					end
					M_DOWN: begin
						if (target_q < floor_q) begin
							floor_d = floor_q - 7'd1;
						end else if (target_q == floor_q) begin
							mode_d = M_OPEN;
							st0    = ST_OPEN;
						end
					end
					default: begin
					end
				endcase
			end
			CMD_KEY: begin
				case (mode_q)
					M_IDLE: begin
						if (key_code == KEY_CONFIRM) begin
							dcnt_d  = 2'd0;
							entry_d = 7'd0;
							if (dcnt_q == 2'd0) begin
								two  = 1'b1;
								ann0 = 1'b1;
								st0  = ST_FAULT;
								flt0 = FLT_EMPTY;
							end else begin
								target_d = entry_q;
								ann0     = 1'b1;
								if (entry_q == floor_q) begin
									two  = 1'b1;
									st0  = ST_FAULT;
									flt0 = FLT_ON_FLOOR;
								end else if (entry_q < floor_q) begin
									mode_d = M_DOWN;
									st0    = ST_DOWN;
								end else begin
									mode_d = M_UP;
									st0    = ST_UP;
								end
							end
						end else if (dcnt_q >= 2'd2) begin
							dcnt_d  = 2'd0;
							entry_d = 7'd0;
							two     = 1'b1;
							ann0    = 1'b1;
							st0     = ST_FAULT;
							flt0    = FLT_TOO_MANY;
						end else if (dig < DIGIT_LIMIT) begin
							if (dcnt_q == 2'd0)
								entry_d = {3'd0, dig4};
							else
								entry_d = (combined > FLOOR_MAX) ? FLOOR_MAX[6:0]
									: combined[6:0];
							dcnt_d = dcnt_q + 2'd1;
						end
					end
					M_EWAIT: begin
						mode_d = M_IDLE;
						two    = 1'b1;
						ann0   = 1'b1;
						st0    = ST_EMERGENCY;
						st1    = ST_EMERG_STOP;
					end
					default: begin
					end
				endcase
			end
			CMD_EMERG: begin
				if (mode_q == M_UP || mode_q == M_DOWN) begin
					mode_d = M_EWAIT;
					ann0   = 1'b1;
					st0    = ST_EMERG_START;
				end
			end
			default: begin
			end
		endcase
	end

	// both results of an event show the state after the event
	always_comb begin
		push.push                 = accept;
		push.two                  = two;
		push.r0.reported_state    = st0;
		push.r0.announce          = ann0;
		push.r0.floor_now         = floor_d;
		push.r0.floor_target      = target_d;
		push.r0.door_is_open      = door_d;
		push.r0.fault_code        = flt0;
		push.r0.last              = !two;
		push.r1.reported_state    = st1;
		push.r1.announce          = 1'b1;
		push.r1.floor_now         = floor_d;
		push.r1.floor_target      = target_d;
		push.r1.door_is_open      = door_d;
		push.r1.fault_code        = FLT_NONE;
		push.r1.last              = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			floor_q  <= FLOOR_RESET;
			target_q <= 7'd0;
			dcnt_q   <= 2'd0;
			entry_q  <= 7'd0;
			door_q   <= 1'b0;
		end else if (accept) begin
			mode_q   <= mode_d;
			floor_q  <= floor_d;
			target_q <= target_d;
			dcnt_q   <= dcnt_d;
			entry_q  <= entry_d;
			door_q   <= door_d;
		end
	end

endmodule

FILE: sv/efc_outq.sv
module efc_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  efc_pkg::push_t   push,
	output logic             space,
	output logic             out_valid,
	input  logic             out_ready,
	output efc_pkg::result_t head
);
	import efc_pkg::*;

	localparam int AW = $clog2(Q_DEPTH);
	localparam logic [AW:0] FREE_LIMIT = (AW + 1)'(Q_DEPTH - 2);

	result_t       entries_q [Q_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   count_q;
	logic [AW:0]   n_push;
	logic          pop;

	assign space     = count_q <= FREE_LIMIT;
	assign out_valid = count_q != '0;
	assign head      = entries_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign n_push    = !push.push ? '0 : (push.two ? (AW + 1)'(2) : (AW + 1)'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + n_push[AW-1:0];
			rd_q    <= rd_q + AW'(pop);
			count_q <= count_q + n_push - (AW + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.push) begin
			entries_q[wr_q] <= push.r0;
			if (push.two)
				entries_q[wr_q + AW'(1)] <= push.r1;
		end
	end

endmodule

FILE: sv/elevator_floor_controller_core.sv
// Channel   Dir  Fields                                          Transfer
// events    in   command, key_code                               valid && ready
// results   out  reported_state, announce, floor_now,            valid && ready
//                floor_target, door_is_open, fault_code, last
//
// One event per cycle while events.ready is high; state updates in the cycle of the transfer.
// Each event yields one or two results, queued in a four-entry result buffer;
// a two-result event (fault, emergency key) writes both results into the buffer at once.
// events.ready is high while at least two buffer entries are free.
// Reset: idle, floor 1, target 0, entry empty, door closed, buffer empty.
module elevator_floor_controller_core (
	input logic        clk,
	input logic        arst_n,
	efc_evt_if.sink    events,
	efc_res_if.source  results
);
	import efc_pkg::*;

	push_t   push;
	result_t head;
	logic    space;
	logic    accept;

	assign events.ready = space;
	assign accept       = events.valid && space;

	efc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.command  (events.command),
		.key_code (events.key_code),
		.push     (push)
	);

	efc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space     (space),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.head      (head)
	);

	assign results.reported_state = head.reported_state;
	assign results.announce       = head.announce;
	assign results.floor_now      = head.floor_now;
	assign results.floor_target   = head.floor_target;
	assign results.door_is_open   = head.door_is_open;
	assign results.fault_code     = head.fault_code;
	assign results.last           = head.last;

endmodule

FILE: sv/efc_checker.sv
module efc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [2:0] res_state,
	input logic       res_announce,
	input logic [6:0] res_floor,
	input logic [6:0] res_target,
	input logic       res_door,
	input logic [1:0] res_fault,
	input logic       res_last
);
	import efc_pkg::*;

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result valid during reset");

	// a fault is always announced and followed by the idle report
	a_fault_pair: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_state == ST_FAULT
		|-> res_announce && !res_last && res_fault != FLT_NONE)
		else $error("bad fault result");

	a_code_only_fault: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_state != ST_FAULT
		|-> res_fault == FLT_NONE)
		else $error("fault code on non-fault result");

	a_emerg_stop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && res_state == ST_EMERGENCY
		|=> res_valid && res_state == ST_EMERG_STOP && res_last)
		else $error("emergency not followed by emergency stop");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready
		|=> res_valid && $stable(res_state) && $stable(res_announce)
			&& $stable(res_floor) && $stable(res_target)
			&& $stable(res_door) && $stable(res_fault)
			&& $stable(res_last))
		else $error("stalled result changed");

endmodule

bind elevator_floor_controller_core efc_checker u_efc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (results.valid),
	.res_ready    (results.ready),
	.res_state    (results.reported_state),
	.res_announce (results.announce),
	.res_floor    (results.floor_now),
	.res_target   (results.floor_target),
	.res_door     (results.door_is_open),
	.res_fault    (results.fault_code),
	.res_last     (results.last)
);

FILE: bench/elevator_floor_controller_core_tb.sv
`timescale 1ns / 100ps

module elevator_floor_controller_core_tb;
	import efc_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;

	efc_evt_if evt();
	efc_res_if res();

	elevator_floor_controller_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.events (evt),
		.results(res)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// car state as the controller should hold it
	state_t     car_mode;
	logic [6:0] car_floor;
	logic [6:0] car_target;
	logic [1:0] entry_digits;
	logic [6:0] entry_val;
	logic       door_open;

	result_t status_due[$];
	result_t step_out[$];

	int idle_pct;
	int stall_pct;
	int events_sent;
	int status_seen;
	int doors_opened;
	int faults_seen;
	int emerg_stops;
	int errors;

	function automatic void emit(state_t st, logic ann, fault_t flt);
		result_t r;
		r.reported_state = st;
		r.announce       = ann;
		r.floor_now      = car_floor;
		r.floor_target   = car_target;
		r.door_is_open   = door_open;
		r.fault_code     = flt;
		r.last           = 1'b0;
		step_out.push_back(r);
	endfunction

	function automatic void emit_fault(fault_t code);
		entry_digits = '0;
		entry_val    = '0;
		car_mode     = ST_IDLE;
		emit(ST_FAULT, 1'b1, code);
		emit(ST_IDLE, 1'b1, FLT_NONE);
		faults_seen++;
	endfunction

	// status words caused by one accepted event
	function automatic void car_response(logic [1:0] cmd, logic [7:0] key);
		logic [7:0] d;
		int         v;
		step_out.delete();
		d = key - KEY_ZERO;
		case (cmd)
			CMD_TICK: begin
				if (car_mode == ST_OPEN) begin
					if (!door_open) begin
						door_open = 1'b1;
						emit(ST_OPEN, 1'b1, FLT_NONE);
						doors_opened++;
					end else begin
						door_open = 1'b0;
						car_mode  = ST_IDLE;
						emit(ST_IDLE, 1'b1, FLT_NONE);
					end
				end else begin
					if (car_mode == ST_UP) begin
						if (car_target > car_floor)
							car_floor++;
						else if (car_target == car_floor)
							car_mode = ST_OPEN;
					end else if (car_mode == ST_DOWN) begin
						if (car_target < car_floor)
							car_floor--;
						else if (car_target == car_floor)
							car_mode = ST_OPEN;
					end
					emit(car_mode, 1'b0, FLT_NONE);
				end
			end
			CMD_KEY: begin
				if (car_mode == ST_IDLE) begin
					if (key == KEY_CONFIRM) begin
						if (entry_digits == 0) begin
							emit_fault(FLT_EMPTY);
						end else begin
							car_target   = entry_val;
							entry_digits = '0;
							entry_val    = '0;
							if (car_target == car_floor) begin
								emit_fault(FLT_ON_FLOOR);
							end else begin
								car_mode = (car_target < car_floor) ? ST_DOWN : ST_UP;
								emit(car_mode, 1'b1, FLT_NONE);
							end
						end
					end else if (entry_digits >= 2) begin
						emit_fault(FLT_TOO_MANY);
					end else begin
						// ':' is taken as digit ten, anything else outside the range is dropped
						if (d < DIGIT_LIMIT) begin
							if (entry_digits == 0) begin
								entry_val = d[6:0];
							end else begin
								v = entry_val * ((d >= DIGIT_WIDE) ? SCALE_HUND : SCALE_TEN) + d;
								entry_val = (v > int'(FLOOR_MAX)) ? FLOOR_MAX[6:0] : v[6:0];
							end
							entry_digits++;
						end
						emit(ST_IDLE, 1'b0, FLT_NONE);
					end
				end else if (car_mode == ST_EMERG_START) begin
					emit(ST_EMERGENCY, 1'b1, FLT_NONE);
					emit(ST_EMERG_STOP, 1'b1, FLT_NONE);
					car_mode = ST_IDLE;
					emerg_stops++;
				end else begin
					emit(car_mode, 1'b0, FLT_NONE);
				end
			end
			default: begin
				if (cmd == CMD_EMERG && (car_mode == ST_UP || car_mode == ST_DOWN)) begin
					car_mode = ST_EMERG_START;
					emit(ST_EMERG_START, 1'b1, FLT_NONE);
				end else begin
					emit(car_mode, 1'b0, FLT_NONE);
				end
			end
		endcase
		step_out[step_out.size() - 1].last = 1'b1;
		foreach (step_out[i])
			status_due.push_back(step_out[i]);
	endfunction

	task automatic send_event(input logic [1:0] cmd, input logic [7:0] key);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			evt.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt.valid    <= 1'b1;
		evt.command  <= cmd;
		evt.key_code <= key;
		@(posedge clk);
		while (!evt.ready)
			@(posedge clk);
		car_response(cmd, key);
		events_sent++;
	endtask

	// hold off the event side until every pending status word is out
	task automatic drain_results();
		evt.valid <= 1'b0;
		do
			@(posedge clk);
		while (status_due.size() != 0);
	endtask

	function automatic logic [7:0] rand_key();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return KEY_ZERO + 8'($urandom_range(10));
		if (r < 60)
			return KEY_CONFIRM;
		return 8'($urandom_range(255));
	endfunction

	// keep ticking (with some noise) until the car is idle again
	task automatic ride_out();
		int r;
		while (car_mode != ST_IDLE) begin
			r = $urandom_range(99);
			if (car_mode == ST_EMERG_START && r < 30)
				send_event(CMD_KEY, rand_key());
			else if (r < 90)
				send_event(CMD_TICK, 8'($urandom_range(255)));
			else if (r < 95)
				send_event(CMD_KEY, rand_key());
			else if (r < 98)
				send_event(CMD_EMERG, 8'($urandom_range(255)));
			else
				send_event(CMD_UNUSED, 8'($urandom_range(255)));
		end
	endtask

	task automatic run_trip();
		int r;
		int t;
		ride_out();
		if (entry_digits != 0) begin
			send_event(CMD_KEY, KEY_CONFIRM);
			ride_out();
		end
		r = $urandom_range(99);
		if (r < 60)
			t = int'(car_floor) + int'($urandom_range(12)) - 6;
		else if (r < 90)
			t = $urandom_range(99);
		else
			t = r[0] ? int'(FLOOR_MAX) : 0;
		if (t < 0)
			t = 0;
		if (t > int'(FLOOR_MAX))
			t = int'(FLOOR_MAX);
		if (t < 10 && $urandom_range(1)) begin
			send_event(CMD_KEY, KEY_ZERO + 8'(t));
		end else begin
			send_event(CMD_KEY, KEY_ZERO + 8'(t / 10));
			send_event(CMD_KEY, KEY_ZERO + 8'(t % 10));
		end
		send_event(CMD_KEY, KEY_CONFIRM);
		ride_out();
	endtask

	task automatic test_entry_faults();
		send_event(CMD_KEY, KEY_CONFIRM);
		send_event(CMD_KEY, KEY_ZERO + 8'd1);
		send_event(CMD_KEY, KEY_CONFIRM);
		send_event(CMD_KEY, KEY_ZERO - 8'd1);
		send_event(CMD_KEY, 8'hFF);
		send_event(CMD_KEY, 8'h00);
		send_event(CMD_KEY, KEY_ZERO + 8'd1);
		send_event(CMD_KEY, KEY_ZERO + 8'd2);
		send_event(CMD_KEY, KEY_ZERO + 8'd3);
	endtask

	task automatic test_trip_down();
		send_event(CMD_TICK, 8'h00);
		send_event(CMD_UNUSED, 8'hFF);
		send_event(CMD_EMERG, 8'h00);
		send_event(CMD_KEY, KEY_ZERO);
		send_event(CMD_KEY, KEY_CONFIRM);
		send_event(CMD_KEY, KEY_ZERO + 8'd7);
		send_event(CMD_TICK, 8'h00);
		send_event(CMD_TICK, 8'h00);
		send_event(CMD_KEY, KEY_CONFIRM);
		send_event(CMD_EMERG, 8'h00);
		send_event(CMD_TICK, 8'h00);
		send_event(CMD_TICK, 8'h00);
	endtask

	task automatic test_saturation_emergency();
		send_event(CMD_KEY, KEY_ZERO + DIGIT_WIDE);
		send_event(CMD_KEY, KEY_ZERO + 8'd5);
		send_event(CMD_KEY, KEY_CONFIRM);
		send_event(CMD_TICK, 8'h00);
		send_event(CMD_EMERG, 8'hFF);
		send_event(CMD_TICK, 8'h00);
		send_event(CMD_EMERG, 8'h00);
		send_event(CMD_KEY, 8'h00);
	endtask

	task automatic test_random_traffic(input int goal, input int idle, input int stall);
		idle_pct  = idle;
		stall_pct = stall;
		while (events_sent < goal) begin
			if ($urandom_range(99) < 30)
				repeat ($urandom_range(1, 4)) send_event(2'($urandom_range(3)), rand_key());
			else
				run_trip();
			if ($urandom_range(99) == 0)
				drain_results();
		end
		drain_results();
	endtask

	function automatic void compare_field(string field, logic [7:0] got, logic [7:0] want);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : status_check
		result_t want;
		if (arst_n && res.valid && res.ready) begin
			status_seen++;
			if (status_due.size() == 0) begin
				$error("status transfer with nothing pending: state %0d", res.reported_state);
				errors++;
			end else begin
				want = status_due.pop_front();
				compare_field("reported_state", res.reported_state, want.reported_state);
				compare_field("announce", res.announce, want.announce);
				compare_field("floor_now", res.floor_now, want.floor_now);
				compare_field("floor_target", res.floor_target, want.floor_target);
				compare_field("door_is_open", res.door_is_open, want.door_is_open);
				compare_field("fault_code", res.fault_code, want.fault_code);
				compare_field("last", res.last, want.last);
			end
		end
		res.ready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		evt.valid    = 1'b0;
		evt.command  = CMD_TICK;
		evt.key_code = '0;
		res.ready    = 1'b0;
		car_mode     = ST_IDLE;
		car_floor    = FLOOR_RESET;
		car_target   = '0;
		entry_digits = '0;
		entry_val    = '0;
		door_open    = 1'b0;
		idle_pct     = 0;
		stall_pct    = 0;
		events_sent  = 0;
		status_seen  = 0;
		doors_opened = 0;
		faults_seen  = 0;
		emerg_stops  = 0;
		errors       = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_entry_faults();
		test_trip_down();
		test_saturation_emergency();
		drain_results();

		test_random_traffic(450, 0, 0);
		test_random_traffic(900, 87, 0);
		test_random_traffic(1300, 0, 87);
		test_random_traffic(1750, 21, 21);

		evt.valid <= 1'b0;
		repeat (10) @(posedge clk);
		$display("%0d events sent, %0d status transfers checked", events_sent, status_seen);
		$display("%0d door openings, %0d entry faults, %0d emergency stops",
			doors_opened, faults_seen, emerg_stops);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
